>>> hdl/seven_segment_text_rasterizer_unit_macros.svh
// assertion macros used by the checker file of the rasterizer
`ifndef SEVEN_SEGMENT_TEXT_RASTERIZER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_RASTERIZER_UNIT_MACROS_SVH

// implication in the same cycle, masked while reset is held
`define SSTR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the following cycle, masked while reset is held
`define SSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sstr_pkg.sv
// types, constants and the segment table of the seven-segment rasterizer
`default_nettype none

package sstr_pkg;

    // register map, one word per register
    typedef enum logic [2:0] {
        REG_START_X      = 3'd0,
        REG_TOP_Y        = 3'd1,
        REG_DIGIT_WIDTH  = 3'd2,
        REG_DIGIT_HEIGHT = 3'd3,
        REG_THICKNESS    = 3'd4,
        REG_CHAR_GAP     = 3'd5,
        REG_DOT_RADIUS   = 3'd6,
        REG_INK_COLOR    = 3'd7
    } t_reg_idx;

    // segment order of emission
    typedef enum logic [2:0] {
        SEG_A = 3'd0,
        SEG_B = 3'd1,
        SEG_C = 3'd2,
        SEG_D = 3'd3,
        SEG_E = 3'd4,
        SEG_F = 3'd5,
        SEG_G = 3'd6
    } t_seg;

    typedef struct packed {
        logic signed [13:0] start_x;
        logic signed [10:0] top_y;
        logic [7:0]         digit_width;
        logic [7:0]         digit_height;
        logic [5:0]         thickness;
        logic [7:0]         char_gap;
        logic [5:0]         dot_radius;
        logic [15:0]        ink_color;
    } t_cfg;

    // one queued character: origin, segments still to draw, dot flag
    typedef struct packed {
        logic signed [14:0] ox;
        logic [6:0]         mask;
        logic               dot;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic signed [17:0] t_coord;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam logic [6:0] DOT_MASK = 7'b000_0001;

    localparam logic signed [15:0] CURSOR_MAX = 16'sd16383;

    localparam int X0_MAX = 16383;
    localparam int Y0_MAX = 2047;
    localparam int X1_MIN = -8192;
    localparam int X1_MAX = 8191;
    localparam int Y1_MIN = -1024;
    localparam int Y1_MAX = 1023;

    // seven-segment pattern, segment a in bit 0
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sstr_front.sv
// front end: takes characters, keeps the cursor and queues drawable ones
`default_nettype none

module sstr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sstr_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_string_start,
    input  sstr_pkg::t_q_status i_q_stat,
    output logic               o_push,
    output sstr_pkg::t_job     o_job
);
    import sstr_pkg::*;

    logic signed [14:0] r_cursor;
    logic signed [14:0] n_cursor;
    logic signed [14:0] base;
    logic signed [15:0] sum;
    logic [8:0]         adv;
    logic               accept;
    logic               is_digit;
    logic               is_dot;

    // a word is taken whenever the queue has room
    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;

    // classify the character
    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign is_dot   = (i_char_code == CHAR_DOT);

    // origin of this character
    assign base = i_string_start ? {i_cfg.start_x[13], i_cfg.start_x} : r_cursor;

    // advance and saturating cursor update
    always_comb begin
        if (is_digit) begin
            adv = {1'b0, i_cfg.digit_width} + {1'b0, i_cfg.char_gap};
        end else if (is_dot) begin
            adv = {2'b0, i_cfg.dot_radius, 1'b0} + {1'b0, i_cfg.char_gap};
        end else begin
            adv = {1'b0, i_cfg.char_gap};
        end
        sum = $signed({base[14], base}) + $signed({7'b0, adv});
        n_cursor = (sum > CURSOR_MAX) ? CURSOR_MAX[14:0] : sum[14:0];
    end

    // queue entry
    always_comb begin
        o_push    = accept && (is_digit || is_dot);
        o_job.ox  = base;
        o_job.dot = is_dot;
        o_job.mask = is_dot ? DOT_MASK : seg_pattern(i_char_code[3:0]);
    end

    // cursor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (accept) begin
            r_cursor <= n_cursor;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sstr_queue.sv
// short job queue between the front end and the rectangle generator
`default_nettype none

module sstr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sstr_pkg::t_job      i_job,
    input  logic                i_pop,
    output sstr_pkg::t_job      o_head,
    output sstr_pkg::t_q_status o_stat
);
    import sstr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/sstr_back.sv
// back end: turns each queued character into clipped rectangles, one a cycle while the output is not stalled
`default_nettype none

module sstr_back #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sstr_pkg::t_cfg      i_cfg,
    input  sstr_pkg::t_job      i_head,
    input  sstr_pkg::t_q_status i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [13:0]         o_rect_x0,
    output logic [10:0]         o_rect_y0,
    output logic signed [13:0]  o_rect_x1,
    output logic signed [10:0]  o_rect_y1,
    output logic [15:0]         o_rect_color,
    output logic                o_last_rect
);
    import sstr_pkg::*;

    logic        r_act;
    logic        n_act;
    t_job        r_job;
    t_job        n_job;
    logic        r_valid;
    logic        n_valid;
    logic        out_free;
    logic        emit;
    logic        last;
    logic [6:0]  rem;
    t_seg        seg;
    t_coord      ox, oy, w, h, t, h2, h2x2, th, r2, r4;
    t_coord      x0, y0, x1, y1;

    // clip helpers
    function automatic logic [13:0] clip_x0(input t_coord v);
        logic [13:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > X0_MAX) begin
            res = 14'(X0_MAX);
        end else begin
            res = v[13:0];
        end
        return res;
    endfunction

    function automatic logic [10:0] clip_y0(input t_coord v);
        logic [10:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > Y0_MAX) begin
            res = 11'(Y0_MAX);
        end else begin
            res = v[10:0];
        end
        return res;
    endfunction

    function automatic logic signed [13:0] clip_x1(input t_coord v);
        t_coord      c;
        logic [13:0] res;
        c = (v > SCREEN_WIDTH) ? t_coord'(SCREEN_WIDTH) : v;
        if (c < X1_MIN) begin
            res = 14'(X1_MIN);
        end else if (c > X1_MAX) begin
            res = 14'(X1_MAX);
        end else begin
            res = c[13:0];
        end
        return res;
    endfunction

    function automatic logic signed [10:0] clip_y1(input t_coord v);
        t_coord      c;
        logic [10:0] res;
        c = (v > SCREEN_HEIGHT) ? t_coord'(SCREEN_HEIGHT) : v;
        if (c < Y1_MIN) begin
            res = 11'(Y1_MIN);
        end else if (c > Y1_MAX) begin
            res = 11'(Y1_MAX);
        end else begin
            res = c[10:0];
        end
        return res;
    endfunction

    // operands, widened with sign where signed
    always_comb begin
        ox   = {{3{r_job.ox[14]}}, r_job.ox};
        oy   = {{7{i_cfg.top_y[10]}}, i_cfg.top_y};
        w    = {10'b0, i_cfg.digit_width};
        h    = {10'b0, i_cfg.digit_height};
        t    = {12'b0, i_cfg.thickness};
        h2   = {11'b0, i_cfg.digit_height[7:1]};
        h2x2 = {10'b0, i_cfg.digit_height[7:1], 1'b0};
        th   = {13'b0, i_cfg.thickness[5:1]};
        r2   = {11'b0, i_cfg.dot_radius, 1'b0};
        r4   = {10'b0, i_cfg.dot_radius, 2'b0};
    end

    // lowest segment still to draw
    always_comb begin
        seg = SEG_A;
        for (int i = 6; i >= 0; i--) begin
            if (r_job.mask[i]) begin
                seg = t_seg'(3'(i));
            end
        end
        rem  = r_job.mask & (r_job.mask - 7'd1);
        last = (rem == '0);
    end

    // segment geometry
    always_comb begin
        x0 = ox;
        y0 = oy;
        x1 = ox;
        y1 = oy;
        if (r_job.dot) begin
            x0 = ox;
            y0 = oy + h - r4;
            x1 = ox + r2;
            y1 = oy + h - r2;
        end else begin
            unique case (seg)
                SEG_A: begin
                    x0 = ox + t;     y0 = oy;
                    x1 = ox + w - t; y1 = oy + t;
                end
                SEG_B: begin
                    x0 = ox + w - t; y0 = oy + t;
                    x1 = ox + w;     y1 = oy + h2 - t;
                end
                SEG_C: begin
                    x0 = ox + w - t; y0 = oy + h2 + t;
                    x1 = ox + w;     y1 = oy + h2x2 - t;
                end
                SEG_D: begin
                    x0 = ox + t;     y0 = oy + h - t;
                    x1 = ox + w - t; y1 = oy + h;
                end
                SEG_E: begin
                    x0 = ox;         y0 = oy + h2 + t;
                    x1 = ox + t;     y1 = oy + h2x2 - t;
                end
                SEG_F: begin
                    x0 = ox;         y0 = oy + t;
                    x1 = ox + t;     y1 = oy + h2 - t;
                end
                SEG_G: begin
                    x0 = ox + t;     y0 = oy + h2 - th;
                    x1 = ox + w - t; y1 = oy + h2 - th + t;
                end
                default: begin
                    x0 = ox;         y0 = oy;
                    x1 = ox;         y1 = oy;
                end
            endcase
        end
    end

    // job sequencing against the output register
    always_comb begin
        out_free = !r_valid || !i_stall;
        emit     = r_act && out_free;
        o_pop    = !i_q_stat.empty && (!r_act || (emit && last));
        n_act    = r_act;
        n_job    = r_job;
        if (o_pop) begin
            n_act = 1'b1;
            n_job = i_head;
        end else if (emit) begin
            n_act = !last;
            n_job.mask = rem;
        end
        if (emit) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_act   <= n_act;
            r_valid <= n_valid;
        end
    end

    // job and output payload
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (emit) begin
            o_rect_x0    <= clip_x0(x0);
            o_rect_y0    <= clip_y0(y0);
            o_rect_x1    <= clip_x1(x1);
            o_rect_y1    <= clip_y1(y1);
            o_rect_color <= i_cfg.ink_color;
            o_last_rect  <= last;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> hdl/seven_segment_text_rasterizer_unit.sv
// Seven-segment text rasterizer: one character word in, clipped fill rectangles out.
// The first rectangle of a character passes the queue entry, the job register and the output register.
// The generator emits one rectangle per cycle while the output is not stalled: a digit gives
// one per lit segment (2 to 7), a dot one, and any other character none.
// A four-entry queue lets input run ahead of the generator; the output register holds on stall.
// Reset (synchronous, active low) clears cursor, queue and valid, and loads register defaults.
`default_nettype none

module seven_segment_text_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // character input
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_string_start,
    // rectangle output
    output logic               o_valid,
    input  logic               i_stall,
    output logic [13:0]        o_rect_x0,
    output logic [10:0]        o_rect_y0,
    output logic signed [13:0] o_rect_x1,
    output logic signed [10:0] o_rect_y1,
    output logic [15:0]        o_rect_color,
    output logic               o_last_rect
);
    import sstr_pkg::*;

    t_cfg      r_cfg;
    t_reg_idx  reg_idx;
    logic      cfg_write;
    logic      push;
    logic      pop;
    t_job      job_in;
    t_job      job_head;
    t_q_status q_stat;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x      <= 14'sd0;
            r_cfg.top_y        <= 11'sd200;
            r_cfg.digit_width  <= 8'd56;
            r_cfg.digit_height <= 8'd88;
            r_cfg.thickness    <= 6'd10;
            r_cfg.char_gap     <= 8'd10;
            r_cfg.dot_radius   <= 6'd6;
            r_cfg.ink_color    <= 16'hFFFF;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_START_X:      r_cfg.start_x      <= pwdata[13:0];
                REG_TOP_Y:        r_cfg.top_y        <= pwdata[10:0];
                REG_DIGIT_WIDTH:  r_cfg.digit_width  <= pwdata[7:0];
                REG_DIGIT_HEIGHT: r_cfg.digit_height <= pwdata[7:0];
                REG_THICKNESS:    r_cfg.thickness    <= pwdata[5:0];
                REG_CHAR_GAP:     r_cfg.char_gap     <= pwdata[7:0];
                REG_DOT_RADIUS:   r_cfg.dot_radius   <= pwdata[5:0];
                REG_INK_COLOR:    r_cfg.ink_color    <= pwdata[15:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_START_X:      prdata = {18'b0, r_cfg.start_x};
            REG_TOP_Y:        prdata = {21'b0, r_cfg.top_y};
            REG_DIGIT_WIDTH:  prdata = {24'b0, r_cfg.digit_width};
            REG_DIGIT_HEIGHT: prdata = {24'b0, r_cfg.digit_height};
            REG_THICKNESS:    prdata = {26'b0, r_cfg.thickness};
            REG_CHAR_GAP:     prdata = {24'b0, r_cfg.char_gap};
            REG_DOT_RADIUS:   prdata = {26'b0, r_cfg.dot_radius};
            REG_INK_COLOR:    prdata = {16'b0, r_cfg.ink_color};
            default:          prdata = '0;
        endcase
    end

    // character intake and cursor
    sstr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_string_start (i_string_start),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_job          (job_in)
    );

    // decoupling queue
    sstr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_stat  (q_stat)
    );

    // rectangle generation
    sstr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (job_head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rect_x0    (o_rect_x0),
        .o_rect_y0    (o_rect_y0),
        .o_rect_x1    (o_rect_x1),
        .o_rect_y1    (o_rect_y1),
        .o_rect_color (o_rect_color),
        .o_last_rect  (o_last_rect)
    );

endmodule

`default_nettype wire

>>> hdl/sstr_checker.sv
// port-level checks of the rasterizer and their binding to the top level
`default_nettype none
`include "seven_segment_text_rasterizer_unit_macros.svh"

module sstr_checker #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [13:0]        o_rect_x0,
    input  logic [10:0]        o_rect_y0,
    input  logic signed [13:0] o_rect_x1,
    input  logic signed [10:0] o_rect_y1,
    input  logic [15:0]        o_rect_color,
    input  logic               o_last_rect
);

    // a stalled rectangle stays put
    `SSTR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_rect_x0, o_rect_y0, o_rect_x1, o_rect_y1, o_rect_color, o_last_rect}), "stalled rectangle changed")

    // right edge never beyond the screen
    `SSTR_ASSERT_SAME(a_x1_clip, i_clk, i_rst_n, o_valid, o_rect_x1 <= SCREEN_WIDTH, "x1 beyond screen width")

    // bottom edge never beyond the screen
    `SSTR_ASSERT_SAME(a_y1_clip, i_clk, i_rst_n, o_valid, o_rect_y1 <= SCREEN_HEIGHT, "y1 beyond screen height")

    // rectangles of one character follow without a gap
    `SSTR_ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_valid && !i_stall && !o_last_rect, o_valid, "gap inside a character")

endmodule

bind seven_segment_text_rasterizer_unit sstr_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_sstr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_rect_x0    (o_rect_x0),
    .o_rect_y0    (o_rect_y0),
    .o_rect_x1    (o_rect_x1),
    .o_rect_y1    (o_rect_y1),
    .o_rect_color (o_rect_color),
    .o_last_rect  (o_last_rect)
);

`default_nettype wire
